[rtl/mf3_pkg.sv]
// ----------------------------------------------------------------------------
// mf3_pkg: shared types and constants of the 3x3 median filter
// widths of the pixel, column, row and fill counters, command and register codes
// ----------------------------------------------------------------------------
package mf3_pkg;

  localparam int MAX_WIDTH     = 1024;
  localparam int PIXEL_BITS    = 8;
  localparam int COL_BITS      = $clog2(MAX_WIDTH);
  localparam int WIDTH_BITS    = 11;
  localparam int HEIGHT_BITS   = 16;
  localparam int PEND_BITS     = $clog2(MAX_WIDTH + 2);
  localparam int WIN_SIZE      = 9;
  localparam int MID_RANK      = 4;
  localparam int APB_DATA_BITS = 32;
  localparam int PADDR_BITS    = 3;
  localparam int WIDTH_RESET   = 640;
  localparam int HEIGHT_RESET  = 480;

  typedef logic [PIXEL_BITS-1:0]  pixel_t;
  typedef logic [COL_BITS-1:0]    col_t;
  typedef logic [COL_BITS:0]      weff_t;
  typedef logic [WIDTH_BITS-1:0]  wid_t;
  typedef logic [HEIGHT_BITS-1:0] hgt_t;
  typedef logic [PEND_BITS-1:0]   pend_t;

  typedef enum logic {
    CMD_PIXEL = 1'b0,
    CMD_FLUSH = 1'b1
  } cmd_t;

  typedef enum logic [PADDR_BITS-3:0] {
    REG_FRAME_WIDTH  = 1'd0,
    REG_FRAME_HEIGHT = 1'd1
  } reg_idx_t;

endpackage

[rtl/mf3_if.sv]
// ----------------------------------------------------------------------------
// mf3 stream interfaces
// pixel/flush command channel and filtered result channel, valid/ready
// ----------------------------------------------------------------------------
interface mf3_pix_if;
  import mf3_pkg::*;

  logic   valid;
  logic   ready;
  cmd_t   cmd;
  pixel_t pixel_in;

  modport source (output valid, output cmd, output pixel_in, input ready);
  modport sink   (input valid, input cmd, input pixel_in, output ready);
endinterface

interface mf3_res_if;
  import mf3_pkg::*;

  logic   valid;
  logic   ready;
  pixel_t pixel_out;
  logic   frame_end;

  modport source (output valid, output pixel_out, output frame_end, input ready);
  modport sink   (input valid, input pixel_out, input frame_end, output ready);
endinterface

[rtl/median_filter_3x3.sv]
// ----------------------------------------------------------------------------
// median_filter_3x3: streaming 3x3 median filter for raster-order frames
// two line stores in synchronous ram, a 3x3 window and a column-sort median
// ----------------------------------------------------------------------------
//
//  channel   | role            | transaction
//  ----------+-----------------+-------------------------------------------
//  raw       | sink, mf3_pix_if| cmd (pixel or flush) + pixel_in
//  filtered  | source,mf3_res_if| pixel_out + frame_end, raster order
//  apb       | slave           | frame_width @ 0x0, frame_height @ 0x4
//
//  one transaction per clock sustained on raw and on filtered while filtered
//  is not stalled; a result shows on filtered once the transaction releasing
//  it has passed ram read, column sort, row of extremes and final
//  median + output register
//  line stores are read when a transaction is taken and written back one
//  stage later; a read of the column being written is served by forwarding
//  rst (synchronous) clears counters, window and pipeline valids; line
//  store contents are not cleared; stalls on filtered back up stage by stage
//
module median_filter_3x3 (
  input  logic                               clk,
  input  logic                               rst,
  mf3_pix_if.sink                            raw,
  mf3_res_if.source                          filtered,
  input  logic                               psel,
  input  logic                               penable,
  input  logic                               pwrite,
  input  logic [mf3_pkg::PADDR_BITS-1:0]     paddr,
  input  logic [mf3_pkg::APB_DATA_BITS-1:0]  pwdata,
  output logic [mf3_pkg::APB_DATA_BITS-1:0]  prdata,
  output logic                               pready
);
  import mf3_pkg::*;

  typedef pixel_t [2:0] trio_t;
  typedef pixel_t [WIN_SIZE-1:0] win_t;

  // stage 1: item waiting for its line store data
  typedef struct packed {
    cmd_t   cmd;
    pixel_t pix;
    col_t   addr;
    logic   emit;
    logic   use_med;
    logic   last;
    logic   sel_newer;
    logic   fwd;
    pixel_t fwd_older;
    pixel_t fwd_newer;
  } s1_t;

  // stage 2: window columns sorted
  typedef struct packed {
    logic   use_med;
    logic   last;
    pixel_t byp;
    trio_t  c0;
    trio_t  c1;
    trio_t  c2;
  } s2_t;

  // stage 3: max of minima, median of middles, min of maxima
  typedef struct packed {
    logic   use_med;
    logic   last;
    pixel_t byp;
    pixel_t lo;
    pixel_t mid;
    pixel_t hi;
  } s3_t;

  // ascending sort of three samples
  function automatic trio_t sort3(input pixel_t a, input pixel_t b, input pixel_t c);
    pixel_t x0, x1, y1, y2, z0, z1;
    trio_t  r;
    x0 = (a < b) ? a : b;
    x1 = (a < b) ? b : a;
    y1 = (x1 < c) ? x1 : c;
    y2 = (x1 < c) ? c : x1;
    z0 = (x0 < y1) ? x0 : y1;
    z1 = (x0 < y1) ? y1 : x0;
    r  = {y2, z1, z0};
    return r;
  endfunction

  function automatic pixel_t med3(input pixel_t a, input pixel_t b, input pixel_t c);
    pixel_t lo, hi;
    lo = (a < b) ? a : b;
    hi = (a < b) ? b : a;
    hi = (hi < c) ? hi : c;
    return (lo > hi) ? lo : hi;
  endfunction

  function automatic pixel_t max3(input pixel_t a, input pixel_t b, input pixel_t c);
    pixel_t m;
    m = (a > b) ? a : b;
    return (m > c) ? m : c;
  endfunction

  function automatic pixel_t min3(input pixel_t a, input pixel_t b, input pixel_t c);
    pixel_t m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  // configuration and frame position
  wid_t  frame_width;
  hgt_t  frame_height;
  weff_t w_eff;
  hgt_t  h_eff;
  col_t  in_col;
  col_t  out_col;
  hgt_t  out_row;
  pend_t pending;

  // line stores and their read data
  pixel_t older_mem [MAX_WIDTH];
  pixel_t newer_mem [MAX_WIDTH];
  pixel_t older_q;
  pixel_t newer_q;

  win_t win;
  win_t win_next;

  logic   s1_valid, s2_valid, s3_valid, out_valid;
  s1_t    s1;
  s2_t    s2;
  s3_t    s3;
  pixel_t out_pixel;
  logic   out_last;

  // handshake
  logic in_fire, in_ready;
  logic s1_go, s1_wr, s2_go, s2_free, s3_go, s3_free, out_free;

  // apb
  logic     cfg_wr;
  reg_idx_t cfg_idx;
  wid_t     fw_new;
  hgt_t     fh_new;
  weff_t    weff_new;

  // stage 0 decode
  logic                is_pixel;
  col_t                pix_col, flush_col, rd_addr;
  weff_t               in_col_inc, out_col_inc;
  logic [HEIGHT_BITS:0] row_inc;
  logic [COL_BITS+1:0] w_plus1, pend_x;
  logic                full, emit, sel_newer, interior, last;
  logic                fwd_hit;

  // stage 1 data
  pixel_t s1_older, s1_newer, byp;

  // --------------------------------------------------------------------------
  // apb register port
  // --------------------------------------------------------------------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[PADDR_BITS-1:2]);
  assign fw_new  = pwdata[WIDTH_BITS-1:0];
  assign fh_new  = pwdata[HEIGHT_BITS-1:0];

  // zero width counts as one, widths past the line store clamp to its depth
  always_comb begin
    if (fw_new == '0) begin
      weff_new = weff_t'(1);
    end else if (32'(fw_new) > 32'(MAX_WIDTH)) begin
      weff_new = weff_t'(MAX_WIDTH);
    end else begin
      weff_new = weff_t'(fw_new);
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_FRAME_WIDTH:  prdata = APB_DATA_BITS'(frame_width);
      REG_FRAME_HEIGHT: prdata = APB_DATA_BITS'(frame_height);
      default:          prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // stage 0: take a transaction, address the line stores, move counters
  // --------------------------------------------------------------------------
  assign is_pixel  = (raw.cmd == CMD_PIXEL);
  assign pix_col   = ({1'b0, in_col} < w_eff) ? in_col : '0;
  assign flush_col = ({1'b0, out_col} < w_eff) ? out_col : '0;
  assign rd_addr   = is_pixel ? pix_col : flush_col;

  assign in_col_inc  = {1'b0, pix_col} + 1'b1;
  assign out_col_inc = {1'b0, out_col} + 1'b1;
  assign row_inc     = {1'b0, out_row} + 1'b1;

  // pipeline of the window is primed once width + 1 pixels are held
  assign w_plus1 = {1'b0, w_eff} + 1'b1;
  assign pend_x  = (COL_BITS+2)'(pending);
  assign full    = (pend_x >= w_plus1);

  // flushed pixel still in the newer store when it sits in the last row taken
  assign sel_newer = ((pend_x - 1'b1) < {1'b0, w_eff});
  assign emit      = is_pixel ? full : (pending != '0);

  assign interior = (out_row != '0) && (row_inc < {1'b0, h_eff}) &&
                    (out_col != '0) && (out_col_inc < w_eff);
  assign last     = (row_inc == {1'b0, h_eff}) && (out_col_inc == w_eff);

  assign in_fire = raw.valid && in_ready;
  assign fwd_hit = s1_wr && (rd_addr == s1.addr);

  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width  <= WIDTH_BITS'(WIDTH_RESET);
      frame_height <= HEIGHT_BITS'(HEIGHT_RESET);
      w_eff        <= weff_t'(WIDTH_RESET);
      h_eff        <= HEIGHT_BITS'(HEIGHT_RESET);
      in_col       <= '0;
      out_col      <= '0;
      out_row      <= '0;
      pending      <= '0;
    end else if (cfg_wr) begin
      // any register write restarts the frame
      case (cfg_idx)
        REG_FRAME_WIDTH: begin
          frame_width <= fw_new;
          w_eff       <= weff_new;
        end
        REG_FRAME_HEIGHT: begin
          frame_height <= fh_new;
          h_eff        <= (fh_new == '0) ? hgt_t'(1) : fh_new;
        end
        default: ;
      endcase
      in_col  <= '0;
      out_col <= '0;
      out_row <= '0;
      pending <= '0;
    end else if (in_fire) begin
      if (is_pixel) begin
        in_col <= (in_col_inc >= w_eff) ? '0 : in_col_inc[COL_BITS-1:0];
        if (!full) begin
          pending <= pending + 1'b1;
        end
      end else if (pending != '0) begin
        pending <= pending - 1'b1;
      end
      if (emit) begin
        if (out_col_inc >= w_eff) begin
          out_col <= '0;
          out_row <= (row_inc >= {1'b0, h_eff}) ? '0 : row_inc[HEIGHT_BITS-1:0];
        end else begin
          out_col <= out_col_inc[COL_BITS-1:0];
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // line stores: read on take, write back when a pixel in stage 1 leaves
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (s1_wr) begin
      older_mem[s1.addr] <= s1_newer;
      newer_mem[s1.addr] <= s1.pix;
    end
    if (in_fire) begin
      older_q <= older_mem[rd_addr];
      newer_q <= newer_mem[rd_addr];
    end
  end

  // --------------------------------------------------------------------------
  // stage 1: line data in, window shift, write back
  // --------------------------------------------------------------------------
  assign s1_go    = s1_valid && (!s1.emit || s2_free);
  assign s1_wr    = s1_go && (s1.cmd == CMD_PIXEL);
  assign in_ready = !s1_valid || s1_go;
  assign raw.ready = in_ready;

  // same column written back on the edge it was read
  assign s1_older = s1.fwd ? s1.fwd_older : older_q;
  assign s1_newer = s1.fwd ? s1.fwd_newer : newer_q;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1.cmd       <= raw.cmd;
      s1.pix       <= raw.pixel_in;
      s1.addr      <= rd_addr;
      s1.emit      <= emit;
      s1.use_med   <= is_pixel && interior;
      s1.last      <= last;
      s1.sel_newer <= sel_newer;
      s1.fwd       <= fwd_hit;
      s1.fwd_older <= s1_newer;
      s1.fwd_newer <= s1.pix;
    end
  end

  // window columns: older row, newer row, current row; newest column on top
  always_comb begin
    for (int i = 0; i < WIN_SIZE - 3; i++) begin
      win_next[i] = win[i+3];
    end
    win_next[WIN_SIZE-3] = s1_older;
    win_next[WIN_SIZE-2] = s1_newer;
    win_next[WIN_SIZE-1] = s1.pix;
  end

  // border pixels keep the centre tap, flushed pixels come from a line store
  assign byp = (s1.cmd == CMD_PIXEL) ? win_next[MID_RANK] :
               (s1.sel_newer ? s1_newer : s1_older);

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (s1_wr) begin
      win <= win_next;
    end
  end

  // --------------------------------------------------------------------------
  // stage 2: sort each window column
  // --------------------------------------------------------------------------
  assign s2_go   = s2_valid && s3_free;
  assign s2_free = !s2_valid || s2_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s2_valid <= 1'b0;
    end else if (s1_go && s1.emit) begin
      s2_valid <= 1'b1;
    end else if (s2_go) begin
      s2_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && s1.emit) begin
      s2.use_med <= s1.use_med;
      s2.last    <= s1.last;
      s2.byp     <= byp;
      s2.c0      <= sort3(win_next[0], win_next[1], win_next[2]);
      s2.c1      <= sort3(win_next[3], win_next[4], win_next[5]);
      s2.c2      <= sort3(win_next[6], win_next[7], win_next[8]);
    end
  end

  // --------------------------------------------------------------------------
  // stage 3: max of minima, median of middles, min of maxima of the column-sorted window
  // --------------------------------------------------------------------------
  assign s3_go   = s3_valid && out_free;
  assign s3_free = !s3_valid || s3_go;

  always_ff @(posedge clk) begin
    if (rst) begin
      s3_valid <= 1'b0;
    end else if (s2_go) begin
      s3_valid <= 1'b1;
    end else if (s3_go) begin
      s3_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s2_go) begin
      s3.use_med <= s2.use_med;
      s3.last    <= s2.last;
      s3.byp     <= s2.byp;
      s3.lo      <= max3(s2.c0[0], s2.c1[0], s2.c2[0]);
      s3.mid     <= med3(s2.c0[1], s2.c1[1], s2.c2[1]);
      s3.hi      <= min3(s2.c0[2], s2.c1[2], s2.c2[2]);
    end
  end

  // --------------------------------------------------------------------------
  // output register
  // --------------------------------------------------------------------------
  assign out_free = !out_valid || filtered.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s3_go) begin
      out_valid <= 1'b1;
    end else if (filtered.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s3_go) begin
      out_pixel <= s3.use_med ? med3(s3.lo, s3.mid, s3.hi) : s3.byp;
      out_last  <= s3.last;
    end
  end

  assign filtered.valid     = out_valid;
  assign filtered.pixel_out = out_pixel;
  assign filtered.frame_end = out_last;

  // --------------------------------------------------------------------------
  // checks
  // --------------------------------------------------------------------------
  // input column leads output column by the fill count, modulo the width
  logic [COL_BITS+1:0] chk_sum, chk_mod1, chk_mod2;
  assign chk_sum  = (COL_BITS+2)'(out_col) + pend_x;
  assign chk_mod1 = (chk_sum >= {1'b0, w_eff}) ? chk_sum - {1'b0, w_eff} : chk_sum;
  assign chk_mod2 = (chk_mod1 >= {1'b0, w_eff}) ? chk_mod1 - {1'b0, w_eff} : chk_mod1;

  a_pending_bound: assert property (@(posedge clk) disable iff (rst)
    pend_x <= w_plus1)
    else $error("fill count past width plus one");

  a_cols_in_range: assert property (@(posedge clk) disable iff (rst)
    ({1'b0, in_col} < w_eff) && ({1'b0, out_col} < w_eff))
    else $error("frame column outside the active width");

  a_col_lag: assert property (@(posedge clk) disable iff (rst)
    in_col == chk_mod2[COL_BITS-1:0])
    else $error("input and output positions out of step with fill count");

endmodule
